// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the predictor restore block.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on the rising clock edge, switched off while reset is low
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/lapr_pkg.sv =====
// Shared types, codes and the fixed polynomial coefficient table
// of the predictor restore block. No dependencies.
package lapr_pkg;

    localparam int COEF_W          = 15;
    localparam int FIXED_MAX_ORDER = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int OUT_W           = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND   = 2'd0,
        CFG_ORDER  = 2'd1,
        CFG_QSHIFT = 2'd2,
        CFG_WSHIFT = 2'd3
    } t_cfg_idx;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic KIND_FIXED = 1'b0;
    localparam logic KIND_LPC   = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    // Tap weights of the fixed polynomial predictors, tap 0 the newest sample
    function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [2:0] order,
                                                            input logic [1:0] tap);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (order)
            3'd1: c = (tap == 2'd0) ? 15'sd1 : 15'sd0;
            3'd2: begin
                case (tap)
                    2'd0:    c = 15'sd2;
                    2'd1:    c = -15'sd1;
                    default: c = 15'sd0;
                endcase
            end
            3'd3: begin
                case (tap)
                    2'd0:    c = 15'sd3;
                    2'd1:    c = -15'sd3;
                    2'd2:    c = 15'sd1;
                    default: c = 15'sd0;
                endcase
            end
            3'd4: begin
                case (tap)
                    2'd0:    c = 15'sd4;
                    2'd1:    c = -15'sd6;
                    2'd2:    c = 15'sd4;
                    default: c = -15'sd1;
                endcase
            end
            default: c = 15'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/lossless_audio_predictor_restore.sv =====
// Top level of the predictor restore block: configuration registers,
// sequencer, coefficient and history RAMs. Depends on lapr_pkg, lapr_ram, lapr_mac.
//
// Restores one channel subframe from residuals using either the fixed
// polynomial predictor (order 0 to 4) or LPC coefficients (order 1 to
// MAX_ORDER), then shifts each sample left by the wasted-bits count. A
// coefficient load request leaves the input ready. A warm-up sample, a
// request under a bad setup, or a fixed order 0 residual goes from idle
// straight to the result state. A residual with order N passes the tap,
// drain and result states: the shared multiply-accumulate unit handles
// one tap per cycle; RAM read, product and sum are registered. The input is
// not ready while a residual is in work; a finished result waits in the
// output register, so the next request may be taken before it is read.
// Coefficient and history RAMs are not cleared at reset; there is no
// clearing pass.
module lossless_audio_predictor_restore #(
    parameter int MAX_ORDER   = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lapr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [5:0]                        i_cfg_wdata,
    // input requests
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [4:0]                        i_coef_index,
    input  logic                              i_block_start,
    input  logic signed [31:0]                i_value,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [lapr_pkg::OUT_W-1:0] o_sample_out,
    output logic                              o_bad_setup
);

`include "assert_macros.svh"

    localparam int HAW = $clog2(MAX_ORDER);
    localparam int OW  = $clog2(MAX_ORDER + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic       r_kind;
    logic [5:0] r_order;
    logic [3:0] r_qshift;
    logic [4:0] r_wshift;

    logic [5:0]     r_wc;
    logic [HAW-1:0] r_wp;
    logic [OW-1:0]  r_j;
    logic [OW-1:0]  r_n;
    logic           r_v1;
    logic           r_bad;
    logic [SAMPLE_BITS-1:0] r_val;
    logic signed [lapr_pkg::COEF_W-1:0] r_fix;

    logic                        r_out_vld;
    logic [lapr_pkg::OUT_W-1:0]  r_out_sample;
    logic                        r_out_bad;

    logic w_in_acc, w_sample_acc, w_bad, w_warm, w_issue, w_done, w_mac_busy;
    logic [5:0] w_wc;
    logic w_coef_we, w_hist_we;
    logic [lapr_pkg::COEF_W-1:0] w_coef_rd;
    logic signed [lapr_pkg::COEF_W-1:0] w_coef;
    logic [SAMPLE_BITS-1:0] w_hist_rd;
    logic [HAW-1:0] w_hist_raddr;
    logic [SAMPLE_BITS-1:0] w_pred;
    logic signed [SAMPLE_BITS-1:0] w_sum;
    logic signed [lapr_pkg::OUT_W-1:0] w_s32;
    logic [lapr_pkg::OUT_W-1:0] w_out;
    logic [3:0] w_shift;
    lapr_pkg::t_mac_ctl w_mac_ctl;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_sample_acc = w_in_acc && (i_func == lapr_pkg::FUNC_SAMPLE);

    assign w_bad = (r_kind == lapr_pkg::KIND_FIXED)
                 ? (r_order > 6'(lapr_pkg::FIXED_MAX_ORDER))
                 : ((r_order == 6'd0) || ({1'b0, r_order} > 7'(MAX_ORDER)));
    assign w_wc   = i_block_start ? 6'd0 : r_wc;
    assign w_warm = (w_wc < r_order);

    assign w_issue = (r_state == S_MAC);
    assign w_done  = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_sample_acc) begin
                    n_state = (w_bad || w_warm || (r_order == 6'd0)) ? S_DONE : S_MAC;
                end
            end
            S_MAC: begin
                if (r_j == r_n - OW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the last product to land in the accumulator
                if (!r_v1 && !w_mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= 1'b0;
            r_order   <= 6'd0;
            r_qshift  <= 4'd0;
            r_wshift  <= 5'd0;
            r_wc      <= 6'd0;
            r_wp      <= '0;
            r_j       <= '0;
            r_v1      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            if (i_cfg_we) begin
                case (lapr_pkg::t_cfg_idx'(i_cfg_idx))
                    lapr_pkg::CFG_KIND:   r_kind   <= i_cfg_wdata[0];
                    lapr_pkg::CFG_ORDER:  r_order  <= i_cfg_wdata;
                    lapr_pkg::CFG_QSHIFT: r_qshift <= i_cfg_wdata[3:0];
                    lapr_pkg::CFG_WSHIFT: r_wshift <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (w_sample_acc) begin
                r_wc <= (!w_bad && w_warm) ? w_wc + 6'd1 : w_wc;
                r_j  <= '0;
            end else if (w_issue) begin
                r_j <= r_j + OW'(1);
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_hist_we) begin
                r_wp <= r_wp + HAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample_acc) begin
            r_val <= i_value[SAMPLE_BITS-1:0];
            r_bad <= w_bad;
            r_n   <= OW'(r_order);
        end
        r_fix <= lapr_pkg::fixed_coef(r_order[2:0], r_j[1:0]);
        if (w_done) begin
            r_out_sample <= r_bad ? '0 : w_out;
            r_out_bad    <= r_bad;
        end
    end

    // Coefficient table: drop loads aimed past the last slot
    assign w_coef_we = w_in_acc && (i_func == lapr_pkg::FUNC_LOAD)
                     && ({1'b0, i_coef_index} < 6'(MAX_ORDER));

    lapr_ram #(
        .W  (lapr_pkg::COEF_W),
        .AW (HAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_coef_index[HAW-1:0]),
        .i_wdata (i_value[lapr_pkg::COEF_W-1:0]),
        .i_raddr (r_j[HAW-1:0]),
        .o_rdata (w_coef_rd)
    );

    // History ring: the newest sample sits just below the write pointer
    assign w_hist_we    = w_done && !r_bad;
    assign w_hist_raddr = r_wp - HAW'(1) - r_j[HAW-1:0];

    lapr_ram #(
        .W  (SAMPLE_BITS),
        .AW (HAW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_wp),
        .i_wdata (w_sum),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rd)
    );

    assign w_coef          = (r_kind == lapr_pkg::KIND_LPC) ? w_coef_rd : r_fix;
    assign w_shift         = (r_kind == lapr_pkg::KIND_LPC) ? r_qshift : 4'd0;
    assign w_mac_ctl.clear = w_sample_acc;
    assign w_mac_ctl.valid = r_v1;

    lapr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_hist  (w_hist_rd),
        .i_shift (w_shift),
        .o_busy  (w_mac_busy),
        .o_pred  (w_pred)
    );

    assign w_sum = r_val + w_pred;
    assign w_s32 = lapr_pkg::OUT_W'(w_sum);
    assign w_out = w_s32 << r_wshift;

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_bad_setup  = r_out_bad;

    `ASSERT_SYNC(a_sample_leaves_idle, i_clk, i_rst_n,
        w_sample_acc |=> (r_state != S_IDLE), "sample request did not start work")
    `ASSERT_SYNC(a_drained_at_done, i_clk, i_rst_n,
        (r_state == S_DONE) |-> (!r_v1 && !w_mac_busy), "result formed before MAC drained")
    `ASSERT_SYNC(a_tap_in_range, i_clk, i_rst_n,
        (r_state == S_MAC) |-> (r_j < r_n), "tap counter ran past the order")
    `ASSERT_SYNC(a_bad_zero, i_clk, i_rst_n,
        (r_out_vld && r_out_bad) |-> (r_out_sample == '0), "bad setup result not zero")
    `ASSERT_ALWAYS(a_reset_clears_out, i_clk,
        !i_rst_n |=> !r_out_vld, "result pending after reset")

endmodule

// ===== hw/rtl/lapr_ram.sv =====
// Simple dual-port RAM with registered read data.
// Used for the coefficient table and the sample history. No dependencies.
module lapr_ram #(
    parameter int W  = 15,
    parameter int AW = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lapr_mac.sv =====
// Shared multiply-accumulate unit: one tap per cycle, registered product and
// accumulator, combinational final arithmetic right shift. Depends on lapr_pkg.
module lapr_mac #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lapr_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [lapr_pkg::COEF_W-1:0] i_coef,
    input  logic signed [SAMPLE_BITS-1:0]      i_hist,
    input  logic [3:0]                         i_shift,
    output logic                               o_busy,
    output logic [SAMPLE_BITS-1:0]             o_pred
);

    // Wide enough for every bit that survives the largest shift
    localparam int PW = lapr_pkg::COEF_W + SAMPLE_BITS;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;
    logic                 r_pv;
    logic signed [PW-1:0] w_shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_hist;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign w_shifted = r_acc >>> i_shift;
    assign o_pred    = w_shifted[SAMPLE_BITS-1:0];
    assign o_busy    = r_pv;

endmodule

// ===== tb/sv/lossless_audio_predictor_restore_tb.sv =====
// Testbench for lossless_audio_predictor_restore: directed and random requests with a
// built-in predictor of the restored samples, checked result by result.
// Depends on lapr_pkg and the block's RTL only.
module lossless_audio_predictor_restore_tb;
    import lapr_pkg::*;

    localparam int MAX_TAPS     = 32;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 850;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               bad;
    } t_restored;

    logic               r_clk         = 1'b0;
    logic               r_rst_n       = 1'b0;
    logic               r_cfg_we      = 1'b0;
    t_cfg_idx           r_cfg_idx     = CFG_KIND;
    logic [5:0]         r_cfg_wdata   = '0;
    logic               r_in_valid    = 1'b0;
    logic               r_func        = FUNC_LOAD;
    logic [4:0]         r_coef_index  = '0;
    logic               r_block_start = 1'b0;
    logic signed [31:0] r_value       = '0;
    logic               r_out_ready   = 1'b0;

    wire                i_clk   = r_clk;
    wire                i_rst_n = r_rst_n;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_sample_out;
    logic               o_bad_setup;

    // predictor state
    logic               cfg_kind   = KIND_FIXED;
    logic [5:0]         cfg_order  = '0;
    logic [3:0]         cfg_qshift = '0;
    logic [4:0]         cfg_wshift = '0;
    logic signed [14:0] coef_mem [MAX_TAPS];
    logic signed [31:0] hist_mem [MAX_TAPS];
    logic [5:0]         warm_cnt   = '0;
    int                 hist_fill  = 0;

    t_restored restored_q [$];
    int        n_fail  = 0;
    int        n_sent  = 0;
    bit        idle_on = 1'b1;

    lossless_audio_predictor_restore u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (r_cfg_we),
        .i_cfg_idx     (r_cfg_idx),
        .i_cfg_wdata   (r_cfg_wdata),
        .i_in_valid    (r_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (r_func),
        .i_coef_index  (r_coef_index),
        .i_block_start (r_block_start),
        .i_value       (r_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (r_out_ready),
        .o_sample_out  (o_sample_out),
        .o_bad_setup   (o_bad_setup)
    );

    initial begin
        forever #1 r_clk = ~r_clk;
    end

    initial begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic setup_is_bad();
        if (cfg_kind == KIND_FIXED) begin
            return cfg_order > FIXED_MAX_ORDER;
        end
        return (cfg_order == 0) || (cfg_order > MAX_TAPS);
    endfunction

    function automatic logic next_is_warmup(input logic start);
        logic [5:0] wc;
        wc = start ? 6'd0 : warm_cnt;
        return !setup_is_bad() && (wc < cfg_order);
    endfunction

    // Force a block start where the next residual would read history never written
    function automatic logic safe_start(input logic start);
        if (!setup_is_bad() && !next_is_warmup(start) && int'(cfg_order) > hist_fill) begin
            return 1'b1;
        end
        return start;
    endfunction

    function automatic void restore_sample(input logic start, input logic signed [31:0] resid);
        t_restored   r;
        longint      pred;
        logic [31:0] s;
        int          j;
        pred = 0;
        if (start) begin
            warm_cnt = '0;
        end
        if (setup_is_bad()) begin
            r.sample = '0;
            r.bad    = 1'b1;
            restored_q.push_back(r);
            return;
        end
        if (warm_cnt < cfg_order) begin
            warm_cnt = warm_cnt + 6'd1;
        end else if (cfg_kind == KIND_FIXED) begin
            case (cfg_order)
                6'd1: pred = longint'(hist_mem[0]);
                6'd2: pred = 2 * longint'(hist_mem[0]) - longint'(hist_mem[1]);
                6'd3: pred = 3 * longint'(hist_mem[0]) - 3 * longint'(hist_mem[1])
                             + longint'(hist_mem[2]);
                6'd4: pred = 4 * longint'(hist_mem[0]) - 6 * longint'(hist_mem[1])
                             + 4 * longint'(hist_mem[2]) - longint'(hist_mem[3]);
                default: pred = 0;
            endcase
        end else begin
            for (j = 0; j < int'(cfg_order); j++) begin
                pred += longint'(coef_mem[j]) * longint'(hist_mem[j]);
            end
            pred = pred >>> cfg_qshift;
        end
        s = resid + pred[31:0];
        for (j = MAX_TAPS - 1; j > 0; j--) begin
            hist_mem[j] = hist_mem[j-1];
        end
        hist_mem[0] = s;
        if (hist_fill < MAX_TAPS) begin
            hist_fill++;
        end
        r.sample = s << cfg_wshift;
        r.bad    = 1'b0;
        restored_q.push_back(r);
    endfunction

    // Drop any request still held so nothing is in flight across the write
    task automatic write_reg(input t_cfg_idx idx, input logic [5:0] data);
        @(negedge i_clk);
        r_in_valid  <= 1'b0;
        r_cfg_we    <= 1'b1;
        r_cfg_idx   <= idx;
        r_cfg_wdata <= data;
        @(negedge i_clk);
        r_cfg_we    <= 1'b0;
        case (idx)
            CFG_KIND:   cfg_kind   = data[0];
            CFG_ORDER:  cfg_order  = data;
            CFG_QSHIFT: cfg_qshift = data[3:0];
            CFG_WSHIFT: cfg_wshift = data[4:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic kind, input logic [5:0] order,
                               input logic [3:0] qshift, input logic [4:0] wshift);
        write_reg(CFG_KIND, {5'd0, kind});
        write_reg(CFG_ORDER, order);
        write_reg(CFG_QSHIFT, {2'd0, qshift});
        write_reg(CFG_WSHIFT, {1'b0, wshift});
    endtask

    // Hold the request until accepted; valid stays high afterwards until the next request, register write or drain
    task automatic send_request(input logic func, input logic [4:0] idx, input logic start,
                                input logic signed [31:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            r_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        r_func        <= func;
        r_coef_index  <= idx;
        r_block_start <= start;
        r_value       <= val;
        r_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (func == FUNC_LOAD) begin
            coef_mem[idx] = val[COEF_W-1:0];
        end else begin
            restore_sample(start, val);
        end
        n_sent++;
    endtask

    task automatic send_load(input logic [4:0] idx, input logic signed [31:0] val);
        send_request(FUNC_LOAD, idx, 1'b0, val);
    endtask

    task automatic send_sample(input logic start, input logic signed [31:0] val);
        send_request(FUNC_SAMPLE, 5'($urandom), safe_start(start), val);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        r_in_valid <= 1'b0;
        while (restored_q.size() != 0) @(posedge i_clk);
        // every result is taken, and each coefficient load was written on acceptance
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                r_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            r_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_restored want;
        if (i_rst_n && o_out_valid && r_out_ready) begin
            if (restored_q.size() == 0) begin
                $error("sample_out: no result expected, got %0d", o_sample_out);
                n_fail++;
            end else begin
                want = restored_q.pop_front();
                if (o_sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, o_sample_out);
                    n_fail++;
                end
                if (o_bad_setup !== want.bad) begin
                    $error("bad_setup: expected %0d, got %0d", want.bad, o_bad_setup);
                    n_fail++;
                end
            end
        end
    end

    // Warm-up count runs from reset with no block start
    task automatic test_count_from_reset();
        apply_setup(KIND_FIXED, 6'd2, 4'd0, 5'd0);
        send_sample(1'b0, 32'sh7FFF_FFFF);
        send_sample(1'b0, 32'sh8000_0000);
        send_sample(1'b0, 32'sh0000_0001);
        send_sample(1'b0, -32'sd1);
        drain_results();
    endtask

    task automatic test_fixed_extremes();
        apply_setup(KIND_FIXED, 6'd4, 4'd0, 5'd31);
        send_sample(1'b1, 32'sh7FFF_FFFF);
        send_sample(1'b0, 32'sh8000_0000);
        send_sample(1'b0, 32'sh7FFF_FFFF);
        send_sample(1'b0, -32'sd1);
        send_sample(1'b0, 32'sh7FFF_FFFF);
        send_sample(1'b0, 32'sh8000_0000);
        drain_results();
        apply_setup(KIND_FIXED, 6'd0, 4'd15, 5'd16);
        send_sample(1'b1, 32'sh8000_0000);
        send_sample(1'b0, 32'sh0001_FFFF);
        drain_results();
    endtask

    // Bad setups flag the result; a block start still clears the warm-up count
    task automatic test_bad_setup();
        apply_setup(KIND_FIXED, 6'd5, 4'd0, 5'd0);
        send_sample(1'b1, 32'sd123);
        send_sample(1'b0, -32'sd5);
        drain_results();
        apply_setup(KIND_LPC, 6'd0, 4'd3, 5'd2);
        send_sample(1'b1, 32'sh5555_AAAA);
        drain_results();
        write_reg(CFG_ORDER, 6'd63);
        send_sample(1'b0, 32'shAAAA_5555);
        drain_results();
        apply_setup(KIND_FIXED, 6'd1, 4'd0, 5'd0);
        send_sample(1'b0, 32'sd100);
        send_sample(1'b0, -32'sd3);
        drain_results();
    endtask

    // Only the low coefficient bits count; upper bits carry noise
    task automatic test_lpc_single_tap();
        send_load(5'd0, 32'shFFFF_C000);
        send_load(5'd31, 32'sh7FFF_BFFF);
        apply_setup(KIND_LPC, 6'd1, 4'd0, 5'd31);
        send_sample(1'b1, 32'sh7FFF_FFFF);
        send_sample(1'b0, 32'sd5);
        send_sample(1'b0, 32'sh8000_0000);
        drain_results();
        apply_setup(KIND_LPC, 6'd1, 4'd15, 5'd0);
        send_sample(1'b0, -32'sd7);
        drain_results();
    endtask

    task automatic test_random_subframes();
        int               base;
        int               n_items;
        int               i;
        int               pos;
        int               sub_len;
        logic             kind;
        logic [5:0]       order;
        logic [3:0]       qshift;
        logic [4:0]       wshift;
        logic             start;
        logic signed [31:0] val;
        base = n_sent;
        for (i = 0; i < MAX_TAPS; i++) begin
            send_load(5'(i), $urandom);
        end
        while (n_sent - base < RANDOM_ITEMS) begin
            drain_results();
            idle_on = ($urandom_range(0, 3) != 0);
            kind = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                if (kind == KIND_FIXED) begin
                    order = 6'($urandom_range(5, 63));
                end else begin
                    order = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
                end
            end else if (kind == KIND_FIXED) begin
                order = 6'($urandom_range(0, FIXED_MAX_ORDER));
            end else begin
                case ($urandom_range(0, 3))
                    0:       order = 6'd1;
                    1:       order = 6'd32;
                    default: order = 6'($urandom_range(1, MAX_TAPS));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       qshift = 4'd0;
                1:       qshift = 4'd15;
                default: qshift = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 5))
                0, 1, 2: wshift = 5'd0;
                3:       wshift = 5'd31;
                default: wshift = 5'($urandom_range(0, 31));
            endcase
            apply_setup(kind, order, qshift, wshift);
            n_items = $urandom_range(30, 80);
            pos     = 0;
            sub_len = int'(order) + $urandom_range(1, 40);
            for (i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_load(5'($urandom), $urandom);
                end else begin
                    if (pos == 0) begin
                        start = ($urandom_range(0, 15) != 0);
                    end else begin
                        start = ($urandom_range(0, 49) == 0);
                    end
                    start = safe_start(start);
                    if ((next_is_warmup(start) && $urandom_range(0, 1)) ||
                        $urandom_range(0, 3) == 0) begin
                        val = $urandom;
                    end else begin
                        val = $urandom_range(0, 1023) - 512;
                    end
                    send_sample(start, val);
                    pos = (pos + 1 >= sub_len) ? 0 : pos + 1;
                end
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        r_rst_n <= 1'b1;
        test_count_from_reset();
        test_fixed_extremes();
        test_bad_setup();
        test_lpc_single_tap();
        test_random_subframes();
        if (n_fail == 0 && restored_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
